@@ sv/tisr_pkg.sv @@
// ----------------------------------------------------------------------------
// tisr_pkg
// Shared types and constants for the time indexed sample ring.
// ----------------------------------------------------------------------------
package tisr_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = AW + 1;

  localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

  localparam logic [1:0] REG_WLEN = 2'd0;
  localparam logic [1:0] REG_NULL = 2'd1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FILL  = 7'b0000010,
    ST_WRITE = 7'b0000100,
    ST_QSET  = 7'b0001000,
    ST_QRD   = 7'b0010000,
    ST_QACC  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // memory port request from sequencer
  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   wdata;
  } mem_req_t;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [LW-1:0] b,
                                             input logic [LW-1:0] w);
    logic [LW:0] s;
    s = {1'b0, 1'b0, a} + {1'b0, b};
    if (s >= {1'b0, w}) s = s - {1'b0, w};
    return s[AW-1:0];
  endfunction

endpackage

@@ sv/tisr_store.sv @@
// ----------------------------------------------------------------------------
// tisr_store
// Single port sample memory with registered read data.
// ----------------------------------------------------------------------------
module tisr_store (
  input  logic               clk,
  input  tisr_pkg::mem_req_t req,
  output logic [31:0]        rdata
);
  import tisr_pkg::*;

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

@@ sv/tisr_acc.sv @@
// ----------------------------------------------------------------------------
// tisr_acc
// Shared accumulate unit: saturating sum and running positive maximum.
// ----------------------------------------------------------------------------
module tisr_acc (
  input  logic                clk,
  input  logic                clr,
  input  logic                en,
  input  logic signed [31:0]  value,
  input  logic signed [31:0]  null_code,
  input  logic [31:0]         vtime,
  output logic signed [47:0]  sum_r,
  output logic [30:0]         max_r,
  output logic                found_r,
  output logic [31:0]         mtime_r
);
  import tisr_pkg::*;

  logic signed [48:0] s;

  assign s = {sum_r[47], sum_r} + 49'(value);

  always_ff @(posedge clk) begin
    if (clr) begin
      sum_r   <= '0;
      max_r   <= '0;
      found_r <= 1'b0;
      mtime_r <= '0;
    end else if (en) begin
      if (value > null_code) begin
        if (s > 49'(SUM_MAX)) sum_r <= SUM_MAX;
        else if (s < 49'(SUM_MIN)) sum_r <= SUM_MIN;
        else sum_r <= s[47:0];
      end
      if (value > $signed({1'b0, max_r})) begin
        max_r   <= value[30:0];
        found_r <= 1'b1;
        mtime_r <= vtime;
      end
    end
  end

endmodule

@@ sv/time_indexed_sample_ring.sv @@
// ----------------------------------------------------------------------------
// time_indexed_sample_ring
// Ring of timestamped samples with gap fill, overwrite and range query.
// ----------------------------------------------------------------------------
// channel | ports                               | handshake
// in      | in_action, in_sample_time, ...      | start & !busy
// out     | out_covered_count ... out_stored_len| out_valid, one cycle
// cfg     | cfg_index, cfg_data                 | cfg_valid & cfg_ready
//
// Insert: FILL nulls each skipped tick (up to window_length - 1), then WRITE, DONE.
// Query: QSET, then QRD and QACC per covered entry (read, accumulate), then DONE.
// Result strobe comes in the same cycle that busy drops.
// Rate is set by the single memory port and the shared accumulate unit.
// Reset empties the ring; memory contents need no clearing.
// The receiver cannot stall; out_valid is high for one cycle per item.
// ----------------------------------------------------------------------------
module time_indexed_sample_ring (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_sample_time,
  input  logic signed [31:0] in_sample_value,
  input  logic [31:0] in_query_begin,
  input  logic [31:0] in_query_end,
  output logic        out_valid,
  output logic [10:0] out_covered_count,
  output logic [31:0] out_before_count,
  output logic [31:0] out_after_count,
  output logic signed [47:0] out_range_sum,
  output logic [30:0] out_max_value,
  output logic        out_max_found,
  output logic [31:0] out_max_time,
  output logic [10:0] out_stored_len,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tisr_pkg::*;

  state_t state_r, state_nxt;
  logic [10:0] wlen_r;
  logic signed [31:0] null_r;
  logic [31:0] ntime_r;
  logic [AW-1:0] nslot_r;
  logic has_r, full_r;

  logic [31:0] t_r;
  logic signed [31:0] v_r;
  logic act_r;
  logic [AW-1:0] pos_r;
  logic [32:0] cnt_r;
  logic [31:0] vt_r, cur_r;
  logic [31:0] bc_r, ac_r;
  logic [10:0] cov_r;
  logic qnull_r;

  mem_req_t req;
  logic [31:0] rdata;
  logic acc_clr, acc_en;
  logic signed [47:0] sum;
  logic [30:0] mx;
  logic fnd;
  logic [31:0] mt;

  logic [LW-1:0] w;
  logic [LW-1:0] held;
  logic [32:0] oldest;
  logic [AW-1:0] di;
  logic [32:0] tn_w;

  always_comb begin
    w = wlen_r;
    if (wlen_r < 11'd2) w = 11'd2;
    if (wlen_r > 11'(DEPTH)) w = LW'(DEPTH);
    held = !has_r ? '0 : (full_r ? w : {1'b0, nslot_r} + 1'b1);
    oldest = {1'b0, ntime_r} - 33'(held) + 33'd1;
    di = full_r ? wrap_add(nslot_r, 11'd1, w) : '0;
    tn_w = {1'b0, ntime_r} + 33'(w);
  end

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = !busy && !start;

  tisr_store u_store (.clk(clk), .req(req), .rdata(rdata));

  tisr_acc u_acc (
    .clk(clk), .clr(acc_clr), .en(acc_en), .value(rdata), .null_code(null_r),
    .vtime(vt_r), .sum_r(sum), .max_r(mx), .found_r(fnd), .mtime_r(mt)
  );

  always_comb begin
    state_nxt = state_r;
    req = '0;
    acc_clr = 1'b0;
    acc_en = 1'b0;
    case (state_r)
      ST_IDLE: begin
        acc_clr = 1'b1;
        if (start) begin
          if (in_action) state_nxt = ST_QSET;
          else state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        req.addr = pos_r;
        req.wdata = null_r;
        if (cnt_r > 33'd1) req.we = 1'b1;
        else state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        req.addr = pos_r;
        req.wdata = v_r;
        req.we = !qnull_r;
        state_nxt = ST_DONE;
      end
      ST_QSET: begin
        state_nxt = (cnt_r == '0) ? ST_DONE : ST_QRD;
      end
      ST_QRD: begin
        req.addr = pos_r;
        state_nxt = ST_QACC;
      end
      ST_QACC: begin
        acc_en = 1'b1;
        state_nxt = (cnt_r == '0) ? ST_DONE : ST_QRD;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wlen_r <= 11'd1024;
      null_r <= 32'sh8000_0000;
      ntime_r <= '0;
      nslot_r <= '0;
      has_r <= 1'b0;
      full_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == ST_DONE);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WLEN: begin
            wlen_r <= cfg_data[10:0];
            ntime_r <= '0;
            nslot_r <= '0;
            has_r <= 1'b0;
            full_r <= 1'b0;
          end
          REG_NULL: null_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            act_r <= in_action;
            t_r <= in_sample_time;
            v_r <= in_sample_value;
            cov_r <= '0;
            if (!in_action) begin
              bc_r <= '0;
              ac_r <= '0;
              if (!has_r || {1'b0, in_sample_time} > tn_w) begin
                pos_r <= '0;
                cnt_r <= '0;
                qnull_r <= 1'b0;
                ntime_r <= in_sample_time;
                nslot_r <= '0;
                has_r <= 1'b1;
                full_r <= 1'b0;
              end else if (in_sample_time > ntime_r) begin
                pos_r <= wrap_add(nslot_r, 11'd1, w);
                cnt_r <= {1'b0, in_sample_time - ntime_r};
                qnull_r <= 1'b0;
                if ({1'b0, nslot_r} + 12'(in_sample_time - ntime_r) >= 12'(w))
                  full_r <= 1'b1;
                ntime_r <= in_sample_time;
              end else begin
                cnt_r <= '0;
                qnull_r <= ({1'b0, in_sample_time} < oldest);
                pos_r <= wrap_add(di, 11'({1'b0, in_sample_time} - oldest), w);
              end
            end else begin
              qnull_r <= 1'b0;
              if (in_query_begin > in_query_end) begin
                cnt_r <= '0;
                bc_r <= '0;
                ac_r <= '0;
              end else if (!has_r || in_query_begin > ntime_r ||
                           {1'b0, in_query_end} < oldest) begin
                cnt_r <= '0;
                ac_r <= '0;
                bc_r <= (in_query_begin == 32'd0 && in_query_end == 32'hFFFF_FFFF) ?
                        32'hFFFF_FFFF : in_query_end - in_query_begin + 32'd1;
              end else begin
                if ({1'b0, in_query_begin} < oldest) begin
                  bc_r <= 32'(oldest - {1'b0, in_query_begin});
                  pos_r <= di;
                  cur_r <= oldest[31:0];
                  cnt_r <= {1'b0, (in_query_end > ntime_r ? ntime_r : in_query_end)}
                           - oldest + 33'd1;
                end else begin
                  bc_r <= '0;
                  pos_r <= wrap_add(di, 11'({1'b0, in_query_begin} - oldest), w);
                  cur_r <= in_query_begin;
                  cnt_r <= {1'b0, (in_query_end > ntime_r ? ntime_r : in_query_end)}
                           - {1'b0, in_query_begin} + 33'd1;
                end
                ac_r <= (in_query_end > ntime_r) ? in_query_end - ntime_r : '0;
              end
            end
          end
        end
        ST_FILL: begin
          if (cnt_r > 33'd1) begin
            pos_r <= wrap_add(pos_r, 11'd1, w);
            cnt_r <= cnt_r - 33'd1;
          end
        end
        ST_WRITE: begin
          if (!qnull_r && t_r == ntime_r) nslot_r <= pos_r;
        end
        ST_QSET: cov_r <= cnt_r[10:0];
        ST_QRD: begin
          vt_r <= cur_r;
          cur_r <= cur_r + 32'd1;
          pos_r <= wrap_add(pos_r, 11'd1, w);
          cnt_r <= cnt_r - 33'd1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_covered_count = act_r ? cov_r : '0;
    out_before_count  = act_r ? bc_r : '0;
    out_after_count   = act_r ? ac_r : '0;
    out_range_sum     = act_r ? sum : '0;
    out_max_value     = act_r ? mx : '0;
    out_max_found     = act_r ? fnd : 1'b0;
    out_max_time      = act_r ? mt : '0;
    out_stored_len    = held;
  end

`ifndef SYNTH
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_valid) else $error("missing result");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE)) else $error("result while busy");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    has_r |-> ({1'b0, nslot_r} < w)) else $error("slot beyond window");
`endif

endmodule

@@ dv/tisr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisr_checker
// Watches the item, result and register channels of the sample ring, keeps
// its own copy of the ring state, predicts every result and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module tisr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_action,
  input  logic [31:0]        in_sample_time,
  input  logic signed [31:0] in_sample_value,
  input  logic [31:0]        in_query_begin,
  input  logic [31:0]        in_query_end,
  input  logic               out_valid,
  input  logic [10:0]        out_covered_count,
  input  logic [31:0]        out_before_count,
  input  logic [31:0]        out_after_count,
  input  logic signed [47:0] out_range_sum,
  input  logic [30:0]        out_max_value,
  input  logic               out_max_found,
  input  logic [31:0]        out_max_time,
  input  logic [10:0]        out_stored_len,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import tisr_pkg::*;

  typedef struct {
    logic [10:0]        covered;
    logic [31:0]        before_n;
    logic [31:0]        after_n;
    logic signed [47:0] sum;
    logic [30:0]        max_v;
    logic               found;
    logic [31:0]        max_t;
    logic [10:0]        stored;
  } ring_result_t;

  ring_result_t expected_results[$];

  logic [31:0] ring_mem [DEPTH];
  logic [31:0] last_time;
  int unsigned last_slot;
  logic        filled_any;
  logic        wrapped;
  logic [10:0] wlen_reg;
  logic [31:0] null_reg;

  assign pending = expected_results.size();

  function automatic longint unsigned active_len();
    if (wlen_reg < 2) return 2;
    if (wlen_reg > DEPTH) return DEPTH;
    return wlen_reg;
  endfunction

  function automatic longint unsigned held_count();
    if (!filled_any) return 0;
    return wrapped ? active_len() : last_slot + 1;
  endfunction

  task automatic apply_insert(input longint unsigned t, input logic [31:0] v);
    longint unsigned w, step, ne, di;
    longint oldest;
    w = active_len();
    if (!filled_any || t > longint'(last_time) + w) begin
      ring_mem[0] = v;
      last_time = t;
      last_slot = 0;
      filled_any = 1;
      wrapped = 0;
    end else if (t > last_time) begin
      step = t - last_time;
      for (longint unsigned k = 1; k < step; k++) ring_mem[(last_slot + k) % w] = null_reg;
      ne = last_slot + step;
      ring_mem[ne % w] = v;
      if (ne >= w) wrapped = 1;
      last_slot = ne % w;
      last_time = t;
    end else begin
      oldest = longint'(last_time) - longint'(held_count()) + 1;
      di = wrapped ? (last_slot + 1) % w : 0;
      if (longint'(t) >= oldest) ring_mem[(di + longint'(t) - oldest) % w] = v;
    end
  endtask

  task automatic range_query(input longint unsigned b, input longint unsigned en,
                             inout ring_result_t r);
    longint unsigned w, tn, di, pos, size, first, rng;
    longint oldest, sum, nul, mx, v;
    w = active_len();
    tn = last_time;
    sum = 0;
    mx = 0;
    nul = longint'(signed'(null_reg));
    if (b > en) return;
    oldest = longint'(tn) - longint'(held_count()) + 1;
    if (!filled_any || b > tn || longint'(en) < oldest) begin
      rng = en - b + 1;
      r.before_n = (rng > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rng[31:0];
      return;
    end
    di = wrapped ? (last_slot + 1) % w : 0;
    if (longint'(b) < oldest) begin
      r.before_n = oldest - longint'(b);
      pos = di;
      first = oldest;
    end else begin
      pos = (di + longint'(b) - oldest) % w;
      first = b;
    end
    if (en > tn) r.after_n = en - tn;
    size = ((en > tn) ? tn : en) - first + 1;
    for (longint unsigned k = 0; k < size; k++) begin
      v = longint'(signed'(ring_mem[pos]));
      if (v > nul) begin
        sum += v;
        if (sum > longint'(SUM_MAX)) sum = SUM_MAX;
        if (sum < longint'(SUM_MIN)) sum = SUM_MIN;
      end
      if (v > mx) begin
        mx = v;
        r.found = 1;
        r.max_t = first + k;
      end
      pos = (pos + 1) % w;
    end
    r.covered = size[10:0];
    r.sum = sum[47:0];
    r.max_v = mx[30:0];
  endtask

  task automatic report(input string field, input longint unsigned got,
                        input longint unsigned exp);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, exp, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    ring_result_t r, e;
    if (!rst_n) begin
      expected_results.delete();
      last_time = 0;
      last_slot = 0;
      filled_any = 0;
      wrapped = 0;
      wlen_reg = 11'd1024;
      null_reg = 32'h8000_0000;
      errors = 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_covered_count !== e.covered) report("covered", out_covered_count, e.covered);
          if (out_before_count !== e.before_n) report("before", out_before_count, e.before_n);
          if (out_after_count !== e.after_n) report("after", out_after_count, e.after_n);
          if (out_range_sum !== e.sum) report("sum", out_range_sum, e.sum);
          if (out_max_value !== e.max_v) report("max_value", out_max_value, e.max_v);
          if (out_max_found !== e.found) report("max_found", out_max_found, e.found);
          if (out_max_time !== e.max_t) report("max_time", out_max_time, e.max_t);
          if (out_stored_len !== e.stored) report("stored_len", out_stored_len, e.stored);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WLEN) begin
          wlen_reg = cfg_data[10:0];
          last_time = 0;
          last_slot = 0;
          filled_any = 0;
          wrapped = 0;
        end else if (cfg_index == REG_NULL) begin
          null_reg = cfg_data;
        end
      end
      if (start && !busy) begin
        r = '{default: '0};
        if (!in_action) apply_insert(in_sample_time, in_sample_value);
        else range_query(in_query_begin, in_query_end, r);
        r.stored = held_count();
        expected_results.push_back(r);
      end
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives inserts, range queries and register writes into the sample ring
// over several window lengths and null codes, with random idle bursts, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
  import tisr_pkg::*;

  localparam int RUN_LIMIT = 6_000_000;
  localparam int DRAIN_CYCLES = 2200;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic               in_action = 0;
  logic [31:0]        in_sample_time = 0;
  logic signed [31:0] in_sample_value = 0;
  logic [31:0]        in_query_begin = 0;
  logic [31:0]        in_query_end = 0;
  logic               out_valid;
  logic [10:0]        out_covered_count;
  logic [31:0]        out_before_count;
  logic [31:0]        out_after_count;
  logic signed [47:0] out_range_sum;
  logic [30:0]        out_max_value;
  logic               out_max_found;
  logic [31:0]        out_max_time;
  logic [10:0]        out_stored_len;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = 0;
  logic [31:0]        cfg_data = 0;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  int                 n_insert = 0;
  int                 n_query = 0;
  int                 n_cfg = 0;
  logic [31:0]        cur_time = 32'd1000;
  int unsigned        cur_wlen = 1024;
  logic [31:0]        cur_null = 32'h8000_0000;
  bit                 idle_on = 1;

  always #4 clk = ~clk;

  time_indexed_sample_ring i_dut (.*);

  tisr_checker i_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic send_item(input logic act, input logic [31:0] t, input logic [31:0] v,
                           input logic [31:0] b, input logic [31:0] e);
    in_action = act;
    in_sample_time = t;
    in_sample_value = v;
    in_query_begin = b;
    in_query_end = e;
    start = 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (act) n_query++;
    else begin
      n_insert++;
      if (t > cur_time || t > cur_time + cur_wlen) cur_time = t;
    end
    maybe_idle();
  endtask

  task automatic drain();
    start = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    drain();
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
    n_cfg++;
    if (idx == REG_WLEN) begin
      cur_wlen = (data[10:0] < 2) ? 2 : (data[10:0] > DEPTH) ? DEPTH : data[10:0];
    end else if (idx == REG_NULL) begin
      cur_null = data;
    end
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return cur_null;
      3: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_insert();
    logic [31:0] t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t = cur_time + $urandom_range(1, 3);
      4: t = cur_time + $urandom_range(1, cur_wlen);
      5: t = cur_time + cur_wlen + $urandom_range(1, 50);
      6, 7: t = cur_time - $urandom_range(0, cur_wlen);
      8: t = cur_time - $urandom_range(cur_wlen, cur_wlen + 20);
      default: t = $urandom;
    endcase
    send_item(1'b0, t, rand_value(), $urandom, $urandom);
  endtask

  task automatic random_query();
    logic [31:0] b, e;
    b = cur_time - $urandom_range(0, cur_wlen + 8);
    e = b + $urandom_range(0, cur_wlen + 8);
    case ($urandom_range(0, 9))
      0: begin
        b = e + $urandom_range(1, 100);
      end
      1: begin
        b = $urandom;
        e = $urandom;
      end
      2: begin
        b = 0;
        e = 32'hFFFF_FFFF;
      end
      default: ;
    endcase
    send_item(1'b1, $urandom, $urandom, b, e);
  endtask

  task automatic random_phase(input int n);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) random_query();
      else random_insert();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: empty ring, time zero, top of time, overwrite, gap, restart
    send_item(1'b1, 0, 0, 5, 10);
    send_item(1'b0, 0, 32'h7FFF_FFFF, 0, 0);
    send_item(1'b1, 0, 0, 0, 0);
    write_reg(REG_WLEN, 11'd4);
    write_reg(REG_NULL, 32'h0000_0000);
    send_item(1'b0, 32'hFFFF_FFF0, 32'h0001_0000, 0, 0);
    send_item(1'b0, 32'hFFFF_FFF3, 32'h8000_0000, 0, 0);
    send_item(1'b0, 32'hFFFF_FFF1, 32'h0002_0000, 0, 0);
    send_item(1'b0, 32'hFFFF_FFEF, 32'h0005_0000, 0, 0);
    send_item(1'b1, 0, 0, 32'hFFFF_FFE0, 32'hFFFF_FFFF);
    send_item(1'b1, 0, 0, 0, 32'hFFFF_FFFF);
    send_item(1'b1, 0, 0, 32'hFFFF_FFF2, 32'hFFFF_FFF1);
    send_item(1'b1, 0, 0, 32'hFFFF_FFF4, 32'hFFFF_FFFF);
    send_item(1'b1, 0, 0, 0, 32'h0000_0010);
    send_item(1'b0, 32'hFFFF_FFF5, 32'h7FFF_FFFF, 0, 0);
    send_item(1'b0, 32'hFFFF_FFF6, 32'h7FFF_FFFF, 0, 0);
    send_item(1'b1, 0, 0, 32'hFFFF_FFF0, 32'hFFFF_FFF8);
    send_item(1'b0, 32'h0000_0005, 32'hFFFF_FFFF, 0, 0);
    send_item(1'b1, 0, 0, 0, 32'h0000_0005);
    drain();

    // random phases across window and null settings, extremes included
    cur_time = $urandom_range(5000, 32'h7FFF_0000);
    write_reg(REG_WLEN, 11'd2);
    write_reg(REG_NULL, 32'h7FFF_FFFF);
    random_phase(80);
    write_reg(REG_WLEN, 11'd0);
    write_reg(REG_NULL, 32'h8000_0000);
    random_phase(50);
    write_reg(REG_WLEN, 11'd16);
    write_reg(REG_NULL, $urandom);
    write_reg(2'd2, $urandom);
    write_reg(2'd3, $urandom);
    random_phase(150);
    write_reg(REG_WLEN, 11'h7FF);
    write_reg(REG_NULL, 32'h0000_0000);
    random_phase(30);
    write_reg(REG_WLEN, $urandom_range(3, 64));
    write_reg(REG_NULL, 32'hFFFF_0000);
    random_phase(120);
    write_reg(REG_WLEN, 11'd1);
    random_phase(40);
    write_reg(REG_WLEN, $urandom_range(5, 40));
    write_reg(REG_NULL, $urandom);
    idle_on = 0;
    random_phase(110);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d inserts, %0d range queries, %0d register writes", n_insert,
             n_query, n_cfg);
    $display("window lengths 2 to 1024, null codes at both extremes and random");
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
